@@ rtl/ils_pkg.sv @@
// Package for the indexed list store: shared types, codes and defaults.
`default_nettype none
package ils_pkg;

   localparam int CAPACITY_DEFAULT = 64;
   localparam int MAX_RESULTS      = 64;

   typedef enum logic [1:0] {
      OP_SEARCH = 2'd0,
      OP_MODIFY = 2'd1,
      OP_APPEND = 2'd2,
      OP_REMOVE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_DONE      = 3'd0,
      ST_MATCH     = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_RANGE     = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_FLUSH
   } state_type;

   // per-cycle commands to the cell row
   typedef struct packed {
      logic rotate;
      logic remove;
      logic append;
   } cell_ctrl_type;

endpackage
`default_nettype wire

@@ rtl/ils_cell.sv @@
// One storage cell of the list: holds one entry, shifts from its upper neighbor.
`default_nettype none
module ils_cell #(
   parameter int CAPACITY = ils_pkg::CAPACITY_DEFAULT,
   parameter int INDEX    = 0
) (
   input  wire logic                             clock,
   input  wire ils_pkg::cell_ctrl_type           ctrl,
   input  wire logic [$clog2(CAPACITY+1)-1:0]    pos,
   input  wire logic [$clog2(CAPACITY+1)-1:0]    count,
   input  wire logic [31:0]                      neighbor_value,
   input  wire logic [31:0]                      operand,
   output      logic [31:0]                      value
);
   import ils_pkg::*;

   localparam int CW = $clog2(CAPACITY+1);
   localparam logic [CW-1:0] MY_INDEX = CW'(INDEX);
   localparam logic [CW-1:0] MY_NEXT  = CW'(INDEX + 1);

   logic [31:0] value_ff;
   logic [31:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (ctrl.rotate) begin
         value_in = neighbor_value;
      end else if (ctrl.remove && (MY_INDEX >= pos) && (MY_NEXT < count)) begin
         value_in = neighbor_value;
      end else if (ctrl.append && (MY_INDEX == count)) begin
         value_in = operand;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule
`default_nettype wire

@@ rtl/indexed_list_store.sv @@
// Top level of the indexed list store: request control and the row of cells.
//
// Usage: requests enter on the req_ channel (valid/ready), each one of
// search, modify, append or remove. Results leave on the rsp_ channel
// (valid/ready), one per request except search, which gives one result per
// matching entry (up to 64) in index order, the final one marked by
// rsp_last_of_run, or a single not-found result.
// Append, remove and rejected requests: the result is registered in the execute
// state once the output register is free; the store then returns to idle.
// Search and valid modify: the entries rotate once through the row of
// CAPACITY cells, one entry per cycle past cell 0 while the rotation is not
// paused, and the final result is then sent from the flush state.
// Only one request is in work at a time; req_ready is high in idle.
// A stalled receiver holds the output register; the rotation then pauses
// whenever a further match must be reported.
// Reset empties the list (count to zero) and drops any pending result;
// entry contents are not cleared and are only read after being written.
`default_nettype none
module indexed_list_store #(
   parameter int CAPACITY = ils_pkg::CAPACITY_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic [1:0]         req_operation,
   input  wire logic [5:0]         req_position,
   input  wire logic signed [31:0] req_operand_value,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic [2:0]         rsp_status,
   output      logic [5:0]         rsp_result_index,
   output      logic signed [31:0] rsp_result_value,
   output      logic [6:0]         rsp_entry_total,
   output      logic               rsp_last_of_run
);
   import ils_pkg::*;

   localparam int CW = $clog2(CAPACITY+1);
   localparam int WW = (CW > 7) ? CW : 7;
   localparam logic [WW-1:0] LAST_STEP = WW'(CAPACITY - 1);
   localparam logic [WW-1:0] FULL_CNT  = WW'(CAPACITY);
   localparam logic [6:0]    MAX_MATCH = 7'(MAX_RESULTS);

   state_type     state_ff, state_in;
   op_type        op_ff, op_in;
   logic [5:0]    pos_ff, pos_in;
   logic [31:0]   operand_ff, operand_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] step_ff, step_in;
   logic          pend_valid_ff, pend_valid_in;
   logic [5:0]    pend_idx_ff, pend_idx_in;
   logic [6:0]    match_cnt_ff, match_cnt_in;
   logic [31:0]   old_ff, old_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    status_ff, status_in;
   logic [5:0]    index_ff, index_in;
   logic [31:0]   value_ff, value_in;
   logic [6:0]    total_ff, total_in;
   logic          last_ff, last_in;

   logic [WW-1:0] count_w, step_w, pos_w, cnt_up, cnt_down;
   logic          out_free, pos_bad, is_full, hit, advance, replace, emit;
   status_type    emit_status;
   logic [5:0]    emit_index;
   logic [31:0]   emit_value;
   logic [WW-1:0] emit_total;
   logic          emit_last;
   cell_ctrl_type ctrl;
   logic [31:0]   rot_tail;
   logic [31:0]   cell_value [CAPACITY];

   assign count_w  = WW'(count_ff);
   assign step_w   = WW'(step_ff);
   assign pos_w    = WW'(pos_ff);
   assign cnt_up   = count_w + WW'(1);
   assign cnt_down = count_w - WW'(1);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pos_bad  = pos_w >= count_w;
   assign is_full  = count_w == FULL_CNT;
   assign hit      = (op_ff == OP_SEARCH) && (step_w < count_w)
                     && (cell_value[0] == operand_ff) && (match_cnt_ff < MAX_MATCH);
   assign replace  = (op_ff == OP_MODIFY) && (step_w == pos_w);
   assign rot_tail = replace ? operand_ff : cell_value[0];

   // cell row
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic [31:0] upper;
      if (k == CAPACITY - 1) begin : g_tail
         assign upper = rot_tail;
      end else begin : g_mid
         assign upper = cell_value[k+1];
      end
      ils_cell #(
         .CAPACITY (CAPACITY),
         .INDEX    (k)
      ) u_cell (
         .clock          (clock),
         .ctrl           (ctrl),
         .pos            (CW'(pos_ff)),
         .count          (count_ff),
         .neighbor_value (upper),
         .operand        (operand_ff),
         .value          (cell_value[k])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (op_ff == OP_SEARCH || (op_ff == OP_MODIFY && !pos_bad)) begin
               state_in = S_SCAN;
            end else if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (advance && step_w == LAST_STEP) state_in = S_FLUSH;
         end
         S_FLUSH: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready   = 1'b0;
      ctrl        = '0;
      advance     = 1'b0;
      emit        = 1'b0;
      emit_status = ST_DONE;
      emit_index  = '0;
      emit_value  = '0;
      emit_total  = count_w;
      emit_last   = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
         end
         S_EXEC: begin
            case (op_ff)
               OP_MODIFY: begin
                  if (pos_bad) begin
                     emit        = out_free;
                     emit_status = ST_RANGE;
                     emit_index  = pos_ff;
                  end
               end
               OP_APPEND: begin
                  emit = out_free;
                  if (is_full) begin
                     emit_status = ST_FULL;
                  end else begin
                     emit_index  = count_w[5:0];
                     emit_total  = cnt_up;
                     ctrl.append = out_free;
                  end
               end
               OP_REMOVE: begin
                  emit       = out_free;
                  emit_index = pos_ff;
                  if (pos_bad) begin
                     emit_status = ST_RANGE;
                  end else begin
                     emit_total  = cnt_down;
                     ctrl.remove = out_free;
                  end
               end
               default: ;
            endcase
         end
         S_SCAN: begin
            advance     = !(hit && pend_valid_ff) || out_free;
            ctrl.rotate = advance;
            emit        = hit && pend_valid_ff && out_free;
            emit_status = ST_MATCH;
            emit_index  = pend_idx_ff;
            emit_value  = operand_ff;
            emit_last   = 1'b0;
         end
         S_FLUSH: begin
            emit = out_free;
            if (op_ff == OP_SEARCH) begin
               if (pend_valid_ff) begin
                  emit_status = ST_MATCH;
                  emit_index  = pend_idx_ff;
                  emit_value  = operand_ff;
               end else begin
                  emit_status = ST_NOT_FOUND;
               end
            end else begin
               emit_index = pos_ff;
               emit_value = old_ff;
            end
         end
         default: ;
      endcase
   end

   // datapath registers
   always_comb begin
      op_in         = op_ff;
      pos_in        = pos_ff;
      operand_in    = operand_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      match_cnt_in  = match_cnt_ff;
      old_in        = old_ff;
      if (req_valid && req_ready) begin
         op_in         = op_type'(req_operation);
         pos_in        = req_position;
         operand_in    = req_operand_value;
         step_in       = '0;
         pend_valid_in = 1'b0;
         match_cnt_in  = '0;
      end
      if (ctrl.append) count_in = CW'(cnt_up);
      if (ctrl.remove) count_in = CW'(cnt_down);
      if (advance) begin
         step_in = step_ff + CW'(1);
         if (replace) old_in = cell_value[0];
         if (hit) begin
            pend_valid_in = 1'b1;
            pend_idx_in   = step_w[5:0];
            match_cnt_in  = match_cnt_ff + 7'd1;
         end
      end
      rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      status_in    = emit ? emit_status : status_ff;
      index_in     = emit ? emit_index : index_ff;
      value_in     = emit ? emit_value : value_ff;
      total_in     = emit ? emit_total[6:0] : total_ff;
      last_in      = emit ? emit_last : last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         step_ff       <= '0;
         pend_valid_ff <= 1'b0;
         match_cnt_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         step_ff       <= step_in;
         pend_valid_ff <= pend_valid_in;
         match_cnt_ff  <= match_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff       <= op_in;
      pos_ff      <= pos_in;
      operand_ff  <= operand_in;
      pend_idx_ff <= pend_idx_in;
      old_ff      <= old_in;
      status_ff   <= status_in;
      index_ff    <= index_in;
      value_ff    <= value_in;
      total_ff    <= total_in;
      last_ff     <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_result_index = index_ff;
   assign rsp_result_value = value_ff;
   assign rsp_entry_total  = total_ff;
   assign rsp_last_of_run  = last_ff;

endmodule
`default_nettype wire

@@ rtl/ils_checker.sv @@
// Port-level checker for the indexed list store, bound to the top level.
`default_nettype none
module ils_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [2:0]         rsp_status,
   input wire logic [5:0]         rsp_result_index,
   input wire logic signed [31:0] rsp_result_value,
   input wire logic [6:0]         rsp_entry_total,
   input wire logic               rsp_last_of_run
);
   import ils_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_result_index) && $stable(rsp_result_value)
         && $stable(rsp_entry_total) && $stable(rsp_last_of_run))
      else $error("result changed while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_MATCH |-> rsp_last_of_run)
      else $error("single result without last marker");

   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_MATCH && !rsp_last_of_run |-> !req_ready)
      else $error("request taken during a search");

   a_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_NOT_FOUND |->
         rsp_result_index == 6'd0 && rsp_result_value == 32'sd0)
      else $error("not-found result carries data");

endmodule

bind indexed_list_store ils_checker u_ils_checker (.*);
`default_nettype wire
